### sv/xtt_pkg.sv
// Shared types and constants for the XML tag tokenizer with charset map.
package xtt_pkg;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  text_byte;
    logic        chunk_end;
    logic [7:0]  entry_index;
    logic [15:0] entry_code;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic       token_start;
    logic       self_closing;
    logic       last_of_run;
  } out_item_t;

  // One accepted text byte, reduced to what the emitter needs.
  typedef struct packed {
    logic      mapped;
    logic      main_valid;
    out_item_t main;
    logic      chunk;
  } job_t;

  typedef enum logic [2:0] {
    MODE_DATA  = 3'd0,
    MODE_OPEN  = 3'd1,
    MODE_SNAME = 3'd2,
    MODE_ATTR  = 3'd3,
    MODE_ENAME = 3'd4,
    MODE_ERR   = 3'd5
  } mode_t;

  localparam logic OP_TEXT  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [2:0] KIND_DATA       = 3'd0;
  localparam logic [2:0] KIND_START_NAME = 3'd1;
  localparam logic [2:0] KIND_ATTR       = 3'd2;
  localparam logic [2:0] KIND_END_NAME   = 3'd3;
  localparam logic [2:0] KIND_START_DONE = 3'd4;
  localparam logic [2:0] KIND_END_DONE   = 3'd5;
  localparam logic [2:0] KIND_ERROR      = 3'd6;
  localparam logic [2:0] KIND_CHUNK_DONE = 3'd7;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;

  localparam logic [15:0] UTF_2B_MIN = 16'h0080;
  localparam logic [15:0] UTF_3B_MIN = 16'h0800;
  localparam logic [7:0]  UTF_LEAD2  = 8'hC0;
  localparam logic [7:0]  UTF_LEAD3  = 8'hE0;
  localparam logic [7:0]  UTF_CONT   = 8'h80;

  localparam logic [2:0] CFG_ADDR_MAP_ENABLE = 3'd0;

endpackage

### sv/xml_tag_tokenizer_with_charset_map.sv
// Top level: XML tag tokenizer with single-byte charset to UTF-8 map.
//
//   port group  direction  handshake            word
//   in_*        input      in_valid / in_stall   xtt_pkg::in_item_t
//   out_*       output     out_valid / out_stall xtt_pkg::out_item_t
//   cfg_*       input      APB psel/penable      map_enable at address 0
//
// A text byte makes up to 4 words, which the output sequencer sends one
// after another; input stalls while a job waits for the sequencer. Results
// pass through the job register, loaded as the charset RAM is read, and
// the sequencer's word list. Table writes make no word.
// Reset clears parser state, map_enable and the pipeline; table contents stay
// undefined until written. A stalled output holds its word and index.
module xml_tag_tokenizer_with_charset_map #(
  parameter int MAP_ENTRIES = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  xtt_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output xtt_pkg::out_item_t out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  import xtt_pkg::*;

  localparam int ADDR_W = $clog2(MAP_ENTRIES);

  logic  map_enable_r;
  logic  in_fire, text_fire, tbl_we;
  logic  job_valid;
  job_t  job;
  logic [15:0] code;
  logic  cfg_sel_map;

  assign in_fire   = in_valid && !in_stall;
  assign text_fire = in_fire && (in_data.opcode == OP_TEXT);
  assign tbl_we    = in_fire && (in_data.opcode == OP_WRITE);

  // Register decode ignores the byte-lane bits.
  assign cfg_sel_map = (cfg_paddr[2] == CFG_ADDR_MAP_ENABLE[2]);
  assign cfg_pready  = 1'b1;
  assign cfg_prdata  = cfg_sel_map ? {31'd0, map_enable_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_enable_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_sel_map) begin
      map_enable_r <= cfg_pwdata[0];
    end
  end

  xtt_ram #(
    .WIDTH (16),
    .DEPTH (MAP_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (in_data.entry_index[ADDR_W-1:0]),
    .wdata (in_data.entry_code),
    .re    (text_fire),
    .raddr (in_data.text_byte[ADDR_W-1:0]),
    .rdata (code)
  );

  xtt_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .text_fire  (text_fire),
    .text_byte  (in_data.text_byte),
    .chunk_end  (in_data.chunk_end),
    .map_enable (map_enable_r),
    .job_valid  (job_valid),
    .job        (job)
  );

  xtt_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .code      (code),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### sv/xtt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module xtt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### sv/xtt_parse.sv
// Tag parser: mode, token and slash state, turns each text byte into a job.
module xtt_parse (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         text_fire,
  input  logic [7:0]   text_byte,
  input  logic         chunk_end,
  input  logic         map_enable,
  output logic         job_valid,
  output xtt_pkg::job_t job
);
  import xtt_pkg::*;

  mode_t mode_r, mode_nxt;
  logic  in_token_r, in_token_nxt;
  logic  slash_r, slash_nxt;

  function automatic logic is_ws(input logic [7:0] c);
    is_ws = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_DATA;
      in_token_r <= 1'b0;
      slash_r    <= 1'b0;
    end else if (text_fire) begin
      mode_r     <= mode_nxt;
      in_token_r <= in_token_nxt;
      slash_r    <= slash_nxt;
    end
  end

  always_comb begin
    mode_nxt     = mode_r;
    in_token_nxt = in_token_r;
    slash_nxt    = slash_r;
    job          = '0;
    job.chunk    = chunk_end;
    unique case (mode_r)
      MODE_DATA: begin
        if (text_byte == CH_LT) begin
          mode_nxt     = MODE_OPEN;
          in_token_nxt = 1'b0;
          slash_nxt    = 1'b0;
        end else if (text_byte == CH_GT) begin
          mode_nxt            = MODE_ERR;
          job.main_valid      = 1'b1;
          job.main.kind       = KIND_ERROR;
        end else if (map_enable) begin
          job.mapped = 1'b1;
        end else begin
          job.main_valid    = 1'b1;
          job.main.kind     = KIND_DATA;
          job.main.out_byte = text_byte;
        end
      end
      MODE_OPEN, MODE_SNAME, MODE_ATTR, MODE_ENAME: begin
        if (text_byte == CH_LT) begin
          mode_nxt       = MODE_ERR;
          job.main_valid = 1'b1;
          job.main.kind  = KIND_ERROR;
        end else if (text_byte == CH_GT) begin
          if (mode_r == MODE_SNAME || mode_r == MODE_ATTR) begin
            job.main_valid        = 1'b1;
            job.main.kind         = KIND_START_DONE;
            job.main.self_closing = slash_r;
          end else if (mode_r == MODE_ENAME) begin
            job.main_valid = 1'b1;
            job.main.kind  = KIND_END_DONE;
          end
          mode_nxt     = MODE_DATA;
          in_token_nxt = 1'b0;
          slash_nxt    = 1'b0;
        end else begin
          if (mode_r == MODE_OPEN) begin
            if (text_byte == CH_SLASH) begin
              mode_nxt = MODE_ENAME;
            end else if (is_ws(text_byte)) begin
              mode_nxt = MODE_ATTR;
            end else begin
              mode_nxt          = MODE_SNAME;
              job.main_valid    = 1'b1;
              job.main.kind     = KIND_START_NAME;
              job.main.out_byte = text_byte;
            end
          end else if (mode_r == MODE_SNAME) begin
            if (is_ws(text_byte) || text_byte == CH_SLASH) begin
              mode_nxt     = MODE_ATTR;
              in_token_nxt = 1'b0;
            end else begin
              job.main_valid    = 1'b1;
              job.main.kind     = KIND_START_NAME;
              job.main.out_byte = text_byte;
            end
          end else if (mode_r == MODE_ATTR) begin
            if (is_ws(text_byte) || text_byte == CH_QUOTE || text_byte == CH_EQ) begin
              in_token_nxt = 1'b0;
            end else begin
              job.main_valid       = 1'b1;
              job.main.kind        = KIND_ATTR;
              job.main.out_byte    = text_byte;
              job.main.token_start = !in_token_r;
              in_token_nxt         = 1'b1;
            end
          end else begin
            job.main_valid    = 1'b1;
            job.main.kind     = KIND_END_NAME;
            job.main.out_byte = text_byte;
          end
          slash_nxt = (text_byte == CH_SLASH);
        end
      end
      MODE_ERR: begin
        job.main_valid = 1'b1;
        job.main.kind  = KIND_ERROR;
      end
      default: begin
        mode_nxt = MODE_DATA;
      end
    endcase
  end

  // Drop bytes that cause no word at all.
  assign job_valid = text_fire && (job.mapped || job.main_valid || job.chunk);

endmodule

### sv/xtt_emit.sv
// Job register and output word sequencer, with UTF-8 expansion of table codes.
module xtt_emit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_valid,
  input  xtt_pkg::job_t    job,
  input  logic [15:0]      code,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output xtt_pkg::out_item_t out_data
);
  import xtt_pkg::*;

  logic      b_valid_r, b_valid_nxt;
  job_t      b_job_r;
  logic      c_valid_r, c_valid_nxt;
  out_item_t c_list_r [4];
  out_item_t list_nxt [4];
  logic [1:0] c_idx_r, c_idx_nxt;
  logic [1:0] c_last_r, last_nxt;
  logic      c_done, b_move;
  logic [2:0] dcnt;
  logic [2:0] cnt;

  assign c_done   = c_valid_r && !out_stall && (c_idx_r == c_last_r);
  assign b_move   = b_valid_r && (!c_valid_r || c_done);
  assign in_stall = b_valid_r && !b_move;

  // Expand the waiting job into its list of words.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      list_nxt[i] = '0;
    end
    dcnt = 3'd0;
    if (b_job_r.mapped) begin
      list_nxt[0].kind = KIND_DATA;
      list_nxt[1].kind = KIND_DATA;
      list_nxt[2].kind = KIND_DATA;
      if (code < UTF_2B_MIN) begin
        list_nxt[0].out_byte = code[7:0];
        dcnt = 3'd1;
      end else if (code < UTF_3B_MIN) begin
        list_nxt[0].out_byte = UTF_LEAD2 | {3'b000, code[10:6]};
        list_nxt[1].out_byte = UTF_CONT | {2'b00, code[5:0]};
        dcnt = 3'd2;
      end else begin
        list_nxt[0].out_byte = UTF_LEAD3 | {4'b0000, code[15:12]};
        list_nxt[1].out_byte = UTF_CONT | {2'b00, code[11:6]};
        list_nxt[2].out_byte = UTF_CONT | {2'b00, code[5:0]};
        dcnt = 3'd3;
      end
    end else if (b_job_r.main_valid) begin
      list_nxt[0] = b_job_r.main;
      dcnt = 3'd1;
    end
    cnt = dcnt;
    if (b_job_r.chunk) begin
      list_nxt[dcnt[1:0]]      = '0;
      list_nxt[dcnt[1:0]].kind = KIND_CHUNK_DONE;
      cnt = dcnt + 3'd1;
    end
    last_nxt = 2'(cnt - 3'd1);
    list_nxt[last_nxt].last_of_run = 1'b1;
  end

  always_comb begin
    b_valid_nxt = b_valid_r;
    if (job_valid) begin
      b_valid_nxt = 1'b1;
    end else if (b_move) begin
      b_valid_nxt = 1'b0;
    end
    c_valid_nxt = c_valid_r;
    c_idx_nxt   = c_idx_r;
    if (b_move) begin
      c_valid_nxt = 1'b1;
      c_idx_nxt   = 2'd0;
    end else if (c_done) begin
      c_valid_nxt = 1'b0;
    end else if (c_valid_r && !out_stall) begin
      c_idx_nxt = c_idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
      c_valid_r <= 1'b0;
      c_idx_r   <= 2'd0;
    end else begin
      b_valid_r <= b_valid_nxt;
      c_valid_r <= c_valid_nxt;
      c_idx_r   <= c_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid) begin
      b_job_r <= job;
    end
    if (b_move) begin
      c_list_r <= list_nxt;
      c_last_r <= last_nxt;
    end
  end

  assign out_valid = c_valid_r;
  assign out_data  = c_list_r[c_idx_r];

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    c_valid_r |-> (c_idx_r <= c_last_r))
    else $error("word index beyond end of list");

  a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
    c_valid_r |-> c_list_r[c_last_r].last_of_run)
    else $error("final word of a run lacks last_of_run");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (c_valid_r && out_stall) |=> (c_valid_r && $stable(c_idx_r)))
    else $error("sequencer advanced while output stalled");

  a_job_held: assert property (@(posedge clk) disable iff (!rst_n)
    (b_valid_r && !b_move) |=> (b_valid_r && $stable(b_job_r)))
    else $error("waiting job lost or changed");

endmodule
